/* design/bppcd_pkg.sv */
// Package for the bit-plane pixel color decoder.
// Holds register indexes, mode codes, color maps and the per-pixel decode function.
// No dependencies.
package bppcd_pkg;

    localparam int NUM_PIX    = 8;
    localparam int PLANE_W    = 8;
    localparam int PIX_W      = 5;
    localparam int CFG_ADDR_W = 2;
    localparam int IN_DATA_W  = 4 * PLANE_W;
    localparam int OUT_DATA_W = NUM_PIX * PIX_W;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_RAW_MODE     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MODE_MASK    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PSEUDO_COLOR = 2'd2;

    localparam logic [PLANE_W-1:0] MODE_MASK_RESET = 8'd31;

    // Effective mode codes
    localparam logic [7:0] MODE_MONO_A   = 8'd0;
    localparam logic [7:0] MODE_MONO_B   = 8'd1;
    localparam logic [7:0] MODE_MAP_BLK  = 8'd4;
    localparam logic [7:0] MODE_MAP_WHT  = 8'd5;
    localparam logic [7:0] MODE_NIB_6    = 8'd6;
    localparam logic [7:0] MODE_NIB_7    = 8'd7;
    localparam logic [7:0] MODE_PSEUDO_E = 8'd14;
    localparam logic [7:0] MODE_PSEUDO_F = 8'd15;

    // Mode group selected by m & 20 in the RGB fallback
    localparam logic [7:0] GRP_MASK = 8'd20;
    localparam logic [7:0] GRP_RGB  = 8'd16;
    localparam logic [7:0] GRP_RGBI = 8'd20;

    localparam logic [PIX_W-1:0] IDX_MONO_A_ON  = 5'd10;
    localparam logic [PIX_W-1:0] IDX_MONO_A_OFF = 5'd0;
    localparam logic [PIX_W-1:0] IDX_MONO_B_ON  = 5'd17;
    localparam logic [PIX_W-1:0] IDX_MONO_B_OFF = 5'd16;
    localparam logic [PIX_W-1:0] IDX_INTENSITY  = 5'd8;
    localparam logic [PIX_W-1:0] IDX_MAX        = 5'd17;

    localparam logic [PIX_W-1:0] MAP_BLACK [4] = '{5'd0, 5'd4, 5'd2, 5'd1};
    localparam logic [PIX_W-1:0] MAP_WHITE [4] = '{5'd7, 5'd4, 5'd2, 5'd1};

    typedef struct packed {
        logic [PLANE_W-1:0] eff_mode;
        logic [PLANE_W-1:0] pseudo_color;
    } cfg_t;

    // One pixel: bits of planes a..d, mode, and the color byte (plane_b or pseudo)
    function automatic logic [PIX_W-1:0] decode_pixel(
        input logic [7:0]         m,
        input logic               pa,
        input logic               pb,
        input logic               pc,
        input logic               pd,
        input logic [PLANE_W-1:0] color
    );
        logic [2:0]       v;
        logic [PIX_W-1:0] res;
        v = {pa, pc, pb};
        unique case (m) inside
            MODE_MONO_A:  res = pa ? IDX_MONO_A_ON : IDX_MONO_A_OFF;
            MODE_MONO_B:  res = pa ? IDX_MONO_B_ON : IDX_MONO_B_OFF;
            MODE_MAP_BLK: res = MAP_BLACK[{pa, pb}];
            MODE_MAP_WHT: res = MAP_WHITE[{pa, pb}];
            MODE_NIB_6, MODE_NIB_7, MODE_PSEUDO_E, MODE_PSEUDO_F:
                res = pa ? {1'b0, color[3:0]} : {1'b0, color[7:4]};
            default:
            begin
                unique case (m & GRP_MASK)
                    GRP_RGB:  res = {2'b00, v};
                    GRP_RGBI: res = (pd && (v != 3'd0)) ? ({2'b00, v} + IDX_INTENSITY)
                                                        : {2'b00, v};
                    default:  res = '0;
                endcase
            end
        endcase
        return res;
    endfunction

endpackage

/* design/bppcd_cfg_regs.sv */
// Configuration registers of the bit-plane pixel color decoder.
// Depends on bppcd_pkg.
module bppcd_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [bppcd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [bppcd_pkg::PLANE_W-1:0]      cfg_wdata,
    output bppcd_pkg::cfg_t                    cfg
);
    import bppcd_pkg::*;

    logic [PLANE_W-1:0] raw_mode_reg, raw_mode_next;
    logic [PLANE_W-1:0] mode_mask_reg, mode_mask_next;
    logic [PLANE_W-1:0] pseudo_color_reg, pseudo_color_next;

    // Register write decode; unknown indexes are dropped
    always_comb
    begin
        raw_mode_next     = raw_mode_reg;
        mode_mask_next    = mode_mask_reg;
        pseudo_color_next = pseudo_color_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_RAW_MODE:     raw_mode_next     = cfg_wdata;
                REG_MODE_MASK:    mode_mask_next    = cfg_wdata;
                REG_PSEUDO_COLOR: pseudo_color_next = cfg_wdata;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_mode_reg     <= '0;
            mode_mask_reg    <= MODE_MASK_RESET;
            pseudo_color_reg <= '0;
        end
        else
        begin
            raw_mode_reg     <= raw_mode_next;
            mode_mask_reg    <= mode_mask_next;
            pseudo_color_reg <= pseudo_color_next;
        end
    end

    assign cfg.eff_mode     = raw_mode_reg & mode_mask_reg;
    assign cfg.pseudo_color = pseudo_color_reg;

endmodule

/* design/bppcd_group_decode.sv */
// Combinational decode of one 8-pixel column group into eight palette indices.
// Depends on bppcd_pkg.
module bppcd_group_decode (
    input  bppcd_pkg::cfg_t                   cfg,
    input  logic [bppcd_pkg::IN_DATA_W-1:0]   planes,
    output logic [bppcd_pkg::OUT_DATA_W-1:0]  pixels
);
    import bppcd_pkg::*;

    logic [PLANE_W-1:0] plane_a, plane_b, plane_c, plane_d;
    logic [PLANE_W-1:0] color;

    assign plane_a = planes[0*PLANE_W +: PLANE_W];
    assign plane_b = planes[1*PLANE_W +: PLANE_W];
    assign plane_c = planes[2*PLANE_W +: PLANE_W];
    assign plane_d = planes[3*PLANE_W +: PLANE_W];

    // Pseudo-color modes replace plane b by the register
    assign color = ((cfg.eff_mode == MODE_PSEUDO_E) || (cfg.eff_mode == MODE_PSEUDO_F))
                   ? cfg.pseudo_color : plane_b;

    // Pixel k comes from bit 7-k of every plane
    always_comb
    begin
        for (int k = 0; k < NUM_PIX; k++)
        begin
            pixels[k*PIX_W +: PIX_W] = decode_pixel(cfg.eff_mode,
                                                    plane_a[NUM_PIX-1-k],
                                                    color[NUM_PIX-1-k],
                                                    plane_c[NUM_PIX-1-k],
                                                    plane_d[NUM_PIX-1-k],
                                                    color);
        end
    end

endmodule

/* design/bitplane_pixel_color_decoder_core.sv */
// Top level of the bit-plane pixel color decoder.
// Depends on bppcd_pkg, bppcd_cfg_regs and bppcd_group_decode.
//
// Usage:
//   s_* channel takes one column group per request: four plane bytes in tdata.
//   m_* channel gives one request of eight 5-bit palette indices per group.
//   The config port writes the raw mode (0), mode_mask (1) and pseudo_color (2);
//   write only while no group is in flight.
// Pipeline: an accepted group is captured in the input register, then decoded
//   into the result register, which drives m_tvalid and m_tdata until the result
//   is taken.
// Throughput: one group per cycle while m_tready stays high; the decode is a single pass of logic
//   between the two registers.
// Reset: both pipeline stages empty, raw mode 0, mode_mask 31,
//   pseudo_color 0.
// Stall: while a result waits and m_tready is low the result register holds; an
//   empty input register still takes one more group, after which s_tready drops
//   until the result is taken.
module bitplane_pixel_color_decoder_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // slave stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bppcd_pkg::IN_DATA_W-1:0]     s_tdata,   // plane_a, plane_b, plane_c, plane_d
    // master stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bppcd_pkg::OUT_DATA_W-1:0]    m_tdata,   // pixel_0 .. pixel_7, 5 bits each
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [bppcd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [bppcd_pkg::PLANE_W-1:0]       cfg_wdata
);
    import bppcd_pkg::*;

    cfg_t                  cfg;
    logic                  in_valid_reg, in_valid_next;
    logic [IN_DATA_W-1:0]  planes_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] pixels_reg;
    logic [OUT_DATA_W-1:0] pixels_dec;
    logic                  advance;
    logic                  in_take;

    bppcd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bppcd_group_decode u_dec (
        .cfg    (cfg),
        .planes (planes_reg),
        .pixels (pixels_dec)
    );

    // Pipeline handshake
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = in_valid_reg;
        end
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            planes_reg <= s_tdata;
        end
        if (advance && in_valid_reg)
        begin
            pixels_reg <= pixels_dec;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = pixels_reg;

    // Range check of the result word for assertions
    logic pix_range_ok;
    always_comb
    begin
        pix_range_ok = 1'b1;
        for (int k = 0; k < NUM_PIX; k++)
        begin
            if (pixels_reg[k*PIX_W +: PIX_W] > IDX_MAX)
            begin
                pix_range_ok = 1'b0;
            end
        end
    end

`ifndef SYNTH
    // Full pipeline with a stalled output must refuse new input
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while both stages full and output stalled");

    // An accepted group always lands in the input register
    a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> in_valid_reg)
        else $error("accepted group lost in input stage");

    // A held input group keeps its planes
    a_hold_planes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> $stable(planes_reg))
        else $error("input stage payload changed while held");

    // Every delivered index lies within the palette range
    a_pix_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pix_range_ok)
        else $error("palette index out of range");
`endif

endmodule
